FILE: rtl/hctb_pkg.sv
// ----------------------------------------------------------------------------
// hctb_pkg
// Shared constants, types and helpers of the codeword tree builder.
// ----------------------------------------------------------------------------
package hctb_pkg;

    localparam int unsigned NODE_COUNT = 2048;
    localparam int unsigned ADDR_W     = $clog2(NODE_COUNT);
    localparam int unsigned CNT_W      = ADDR_W + 1;
    localparam int unsigned LEVELS     = 32;
    localparam int unsigned LVL_W      = $clog2(LEVELS);
    localparam int unsigned INDEX_W    = 11;
    localparam int unsigned LEN_W      = 6;
    localparam int unsigned CW_W       = 32;

    localparam logic       OP_CLEAR  = 1'b0;
    localparam logic       OP_INSERT = 1'b1;
    localparam logic       ST_OK     = 1'b0;
    localparam logic       ST_FULL   = 1'b1;
    localparam logic [15:0] LEAF_FLAG = 16'h8000;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_MK_WALK  = 8'b0000_0010,
        S_MK_WRITE = 8'b0000_0100,
        S_TR_START = 8'b0000_1000,
        S_TR_READ  = 8'b0001_0000,
        S_TR_CHECK = 8'b0010_0000,
        S_TR_PLACE = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic accept;
        logic mk_walk;
        logic mk_write;
        logic tr_start;
        logic tr_read;
        logic tr_follow;
        logic tr_drop;
        logic tr_place;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_insert;
        logic walk_done;
        logic write_last;
        logic root_empty;
        logic follow;
        logic fits;
        logic depth_zero;
        logic out_free;
    } sts_t;

    function automatic logic [31:0] set_half(input logic [31:0] word, input logic sel,
                                             input logic [15:0] half);
        logic [31:0] res;
        res = sel ? {half, word[15:0]} : {word[31:16], half};
        return res;
    endfunction

endpackage

FILE: rtl/hctb_chan_if.sv
// ----------------------------------------------------------------------------
// hctb channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hctb_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [hctb_pkg::INDEX_W-1:0]  entry_index;
    logic [hctb_pkg::LEN_W-1:0]    code_length;

    modport source (output valid, output opcode, output entry_index, output code_length,
                    input ready);
    modport sink   (input valid, input opcode, input entry_index, input code_length,
                    output ready);
endinterface

interface hctb_out_if;
    logic                         valid;
    logic                         ready;
    logic [hctb_pkg::CW_W-1:0]    codeword;
    logic [hctb_pkg::CNT_W-1:0]   nodes_used;
    logic                         status;

    modport source (output valid, output codeword, output nodes_used, output status,
                    input ready);
    modport sink   (input valid, input codeword, input nodes_used, input status,
                    output ready);
endinterface

FILE: rtl/hctb_ctrl.sv
// ----------------------------------------------------------------------------
// hctb_ctrl
// Sequencer for marker walk, marker rewrite and tree insertion.
// ----------------------------------------------------------------------------
module hctb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  hctb_pkg::sts_t    sts,
    output hctb_pkg::cmd_t    cmd,
    output hctb_pkg::state_t  state
);

    hctb_pkg::state_t state_reg;
    hctb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hctb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            hctb_pkg::S_IDLE:
            begin
                if (sts.in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.in_insert ? hctb_pkg::S_MK_WALK : hctb_pkg::S_DONE;
                end
            end
            hctb_pkg::S_MK_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = hctb_pkg::S_MK_WRITE;
                end
                else
                begin
                    cmd.mk_walk = 1'b1;
                end
            end
            hctb_pkg::S_MK_WRITE:
            begin
                cmd.mk_write = 1'b1;
                if (sts.write_last)
                begin
                    state_next = hctb_pkg::S_TR_START;
                end
            end
            hctb_pkg::S_TR_START:
            begin
                cmd.tr_start = 1'b1;
                state_next   = sts.root_empty ? hctb_pkg::S_TR_CHECK : hctb_pkg::S_TR_READ;
            end
            hctb_pkg::S_TR_READ:
            begin
                cmd.tr_read = 1'b1;
                state_next  = hctb_pkg::S_TR_CHECK;
            end
            hctb_pkg::S_TR_CHECK:
            begin
                if (sts.follow)
                begin
                    cmd.tr_follow = 1'b1;
                    state_next    = hctb_pkg::S_TR_READ;
                end
                else if (sts.fits)
                begin
                    state_next = hctb_pkg::S_TR_PLACE;
                end
                else
                begin
                    cmd.tr_drop = 1'b1;
                    state_next  = hctb_pkg::S_DONE;
                end
            end
            hctb_pkg::S_TR_PLACE:
            begin
                cmd.tr_place = 1'b1;
                if (sts.depth_zero)
                begin
                    state_next = hctb_pkg::S_DONE;
                end
            end
            hctb_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = hctb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hctb_pkg::S_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

FILE: rtl/hctb_datapath.sv
// ----------------------------------------------------------------------------
// hctb_datapath
// Length markers, codeword register, node store and result register.
// ----------------------------------------------------------------------------
module hctb_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  hctb_pkg::cmd_t  cmd,
    output hctb_pkg::sts_t  sts,
    hctb_in_if.sink         item,
    hctb_out_if.source      result
);

    logic [hctb_pkg::CW_W-1:0]    markers_reg [hctb_pkg::LEVELS];
    logic [hctb_pkg::CW_W-1:0]    node_mem    [hctb_pkg::NODE_COUNT];
    logic [hctb_pkg::CW_W-1:0]    rd_data_reg;
    logic [hctb_pkg::CW_W-1:0]    cw_reg;
    logic [hctb_pkg::CW_W-1:0]    word_reg;
    logic [hctb_pkg::LVL_W-1:0]   lm1_reg;
    logic [hctb_pkg::LVL_W-1:0]   jp_reg;
    logic [hctb_pkg::LVL_W-1:0]   depth_reg;
    logic [hctb_pkg::ADDR_W-1:0]  pos_reg;
    logic [hctb_pkg::INDEX_W-1:0] index_reg;
    logic [hctb_pkg::CNT_W-1:0]   nfn_reg;
    logic                         zero_word_reg;
    logic                         status_reg;
    logic                         out_valid_reg;
    logic [hctb_pkg::CW_W-1:0]    out_cw_reg;
    logic [hctb_pkg::CNT_W-1:0]   out_nodes_reg;
    logic                         out_status_reg;

    logic [hctb_pkg::LEN_W-1:0]   len_c;
    logic [hctb_pkg::LVL_W-1:0]   lm1_in;
    logic [hctb_pkg::LVL_W-1:0]   mk_idx;
    logic [hctb_pkg::CW_W-1:0]    mk_rd;
    logic [hctb_pkg::LEN_W-1:0]   len_full;
    logic [hctb_pkg::CW_W-1:0]    len_mask;
    logic [hctb_pkg::CW_W-1:0]    cur_word;
    logic [15:0]                  cur_half;
    logic                         is_ptr;
    logic                         path_bit;
    logic [15:0]                  place_half;
    logic [hctb_pkg::CNT_W:0]     room;
    logic                         mem_we;

    // length clamp and marker read
    always_comb
    begin
        if (item.code_length == '0)
        begin
            len_c = hctb_pkg::LEN_W'(1);
        end
        else if (item.code_length > hctb_pkg::LEN_W'(hctb_pkg::LEVELS))
        begin
            len_c = hctb_pkg::LEN_W'(hctb_pkg::LEVELS);
        end
        else
        begin
            len_c = item.code_length;
        end
        lm1_in   = hctb_pkg::LVL_W'(len_c - hctb_pkg::LEN_W'(1));
        mk_idx   = cmd.accept ? lm1_in : (jp_reg - hctb_pkg::LVL_W'(1));
        mk_rd    = markers_reg[mk_idx];
        len_full = {1'b0, lm1_reg} + hctb_pkg::LEN_W'(1);
        len_mask = ~({hctb_pkg::CW_W{1'b1}} << len_full);
    end

    // tree walk evaluation
    always_comb
    begin
        cur_word   = zero_word_reg ? '0 : rd_data_reg;
        path_bit   = cw_reg[depth_reg];
        cur_half   = path_bit ? cur_word[31:16] : cur_word[15:0];
        is_ptr     = (cur_half != '0) && !cur_half[15]
                     && (cur_half[14:0] < 15'(nfn_reg));
        room       = (hctb_pkg::CNT_W + 1)'(hctb_pkg::NODE_COUNT) - {1'b0, nfn_reg};
        place_half = (depth_reg == '0)
                     ? (hctb_pkg::LEAF_FLAG | 16'(index_reg))
                     : 16'(nfn_reg[hctb_pkg::ADDR_W-1:0]);
        mem_we     = cmd.tr_place;
    end

    assign sts.in_valid   = item.valid;
    assign sts.in_insert  = (item.opcode == hctb_pkg::OP_INSERT);
    assign sts.walk_done  = (jp_reg == '0) || cw_reg[0];
    assign sts.write_last = (jp_reg == lm1_reg);
    assign sts.root_empty = (nfn_reg == '0);
    assign sts.follow     = is_ptr && (depth_reg != '0);
    assign sts.fits       = ((hctb_pkg::CNT_W + 1)'(depth_reg) <= room);
    assign sts.depth_zero = (depth_reg == '0);
    assign sts.out_free   = !out_valid_reg || result.ready;

    // markers, allocator and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hctb_pkg::LEVELS; i++)
            begin
                markers_reg[i] <= '0;
            end
            nfn_reg       <= '0;
            zero_word_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && (item.opcode == hctb_pkg::OP_CLEAR))
            begin
                for (int i = 0; i < hctb_pkg::LEVELS; i++)
                begin
                    markers_reg[i] <= '0;
                end
                nfn_reg <= '0;
            end
            if (cmd.mk_write)
            begin
                markers_reg[jp_reg] <= cw_reg + hctb_pkg::CW_W'(1);
            end
            if (cmd.tr_start && (nfn_reg == '0))
            begin
                nfn_reg       <= hctb_pkg::CNT_W'(1);
                zero_word_reg <= 1'b1;
            end
            if (cmd.tr_read)
            begin
                zero_word_reg <= 1'b0;
            end
            if (cmd.tr_place && (depth_reg != '0))
            begin
                nfn_reg <= nfn_reg + hctb_pkg::CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            index_reg  <= item.entry_index;
            lm1_reg    <= lm1_in;
            jp_reg     <= lm1_in;
            cw_reg     <= (item.opcode == hctb_pkg::OP_INSERT) ? mk_rd : '0;
            status_reg <= hctb_pkg::ST_OK;
        end
        if (cmd.mk_walk)
        begin
            cw_reg <= mk_rd;
            jp_reg <= jp_reg - hctb_pkg::LVL_W'(1);
        end
        if (cmd.mk_write)
        begin
            if (jp_reg == lm1_reg)
            begin
                cw_reg <= cw_reg & len_mask;
            end
            else
            begin
                cw_reg <= cw_reg << 1;
                jp_reg <= jp_reg + hctb_pkg::LVL_W'(1);
            end
        end
        if (cmd.tr_start)
        begin
            pos_reg   <= '0;
            depth_reg <= lm1_reg;
        end
        if (cmd.tr_follow)
        begin
            pos_reg   <= cur_half[hctb_pkg::ADDR_W-1:0];
            depth_reg <= depth_reg - hctb_pkg::LVL_W'(1);
        end
        if (sts.fits && !sts.follow && !cmd.tr_place)
        begin
            word_reg <= cur_word;
        end
        if (cmd.tr_drop)
        begin
            status_reg <= hctb_pkg::ST_FULL;
        end
        if (cmd.tr_place && (depth_reg != '0))
        begin
            pos_reg   <= nfn_reg[hctb_pkg::ADDR_W-1:0];
            depth_reg <= depth_reg - hctb_pkg::LVL_W'(1);
            word_reg  <= '0;
        end
        if (cmd.out_load)
        begin
            out_cw_reg     <= cw_reg;
            out_nodes_reg  <= nfn_reg;
            out_status_reg <= status_reg;
        end
    end

    // node store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[pos_reg] <= hctb_pkg::set_half(word_reg, path_bit, place_half);
        end
        if (cmd.tr_read)
        begin
            rd_data_reg <= node_mem[pos_reg];
        end
    end

    assign item.ready        = cmd.accept;
    assign result.valid      = out_valid_reg;
    assign result.codeword   = out_cw_reg;
    assign result.nodes_used = out_nodes_reg;
    assign result.status     = out_status_reg;

endmodule

FILE: rtl/huffman_codeword_tree_builder_unit.sv
// ----------------------------------------------------------------------------
// huffman_codeword_tree_builder_unit
// Assigns codewords from length markers and builds the binary decode tree.
//
//   channel   dir   payload
//   item      in    opcode, entry_index, code_length
//   result    out   codeword, nodes_used, status
//
// a clear goes straight to the result; an insert runs the marker walk, the marker
// rewrite and the tree walk, placing one node per new level, then the handshake
// the node store has one port, so each tree level costs a read and a check
// reset clears markers, node count and handshake state; node words are not reset
// a finished result waits in the output register while the next request is taken
// ----------------------------------------------------------------------------
module huffman_codeword_tree_builder_unit (
    input  logic        clk,
    input  logic        rst_n,
    hctb_in_if.sink     item,
    hctb_out_if.source  result
);

    hctb_pkg::cmd_t   cmd;
    hctb_pkg::sts_t   sts;
    hctb_pkg::state_t state;

    hctb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd),
        .state (state)
    );

    hctb_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .item   (item),
        .result (result)
    );

    a_nodes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.nodes_used <= hctb_pkg::CNT_W'(hctb_pkg::NODE_COUNT)))
        else $error("node count beyond store size");

    a_full_near_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status == hctb_pkg::ST_FULL))
        |-> (result.nodes_used > hctb_pkg::CNT_W'(hctb_pkg::NODE_COUNT - hctb_pkg::LEVELS)))
        else $error("full status with room left");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> (!item.ready && (state != hctb_pkg::S_IDLE)))
        else $error("request taken while busy");

endmodule
